>>> hdl/triple_page_delta_decoder_macros.svh
// Assertion macros shared by the page decoder RTL
`ifndef TRIPLE_PAGE_DELTA_DECODER_MACROS_SVH
`define TRIPLE_PAGE_DELTA_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define TPDD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tpdd check failed");

// Next-cycle implication, disabled while reset is held
`define TPDD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tpdd check failed");

`endif

>>> hdl/tpdd_pkg.sv
// Constants and types of the leaf page triple decoder
package tpdd_pkg;

    localparam int PAGE_BYTES   = 16384;
    localparam int HEADER_BYTES = 12;
    localparam int FIRST_BYTES  = 12;
    // position counter holds PAGE_BYTES itself once the page is used up
    localparam int POS_W        = $clog2(PAGE_BYTES + 1);
    localparam int KEY_W        = 32;
    localparam int LEN_W        = 3;

    // long codes whose low seven bits reach this value repeat the previous triple
    localparam logic [6:0] REPEAT_MIN = 7'd125;
    localparam logic [7:0] CODE_END   = 8'd0;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FIRST,
        PH_CODE,
        PH_FA,
        PH_FB,
        PH_FC
    } phase_t;

    typedef struct packed {
        logic             first;
        logic [KEY_W-1:0] count;
        logic [KEY_W-1:0] second;
        logic [KEY_W-1:0] first_key;
    } result_t;

endpackage

>>> hdl/triple_page_delta_decoder.sv
// Leaf page triple decoder: byte stream in, decoded key triples out
//
//  channel | dir | tdata (low bit up)                       | tuser
//  s_      | in  | page_byte[7:0]                           | page_first
//  m_      | out | first_value, second_value, entry_count   | entry_first
//
// One byte is taken per cycle while s_tready is high; decode and state update are
// combinational between the accepted byte and the result register.
// A result goes to m_ through the output register, or the skid register on a stall.
// Output register plus one skid register: s_tready drops only when both hold.
// aresetn is synchronous, active low, and clears all control and key state.
module triple_page_delta_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // page_byte[7:0]
    input  logic        s_tuser,   // page_first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // first_value[31:0], second_value[63:32],
                                   // entry_count[95:64]
    output logic        m_tuser    // entry_first
);

    `include "triple_page_delta_decoder_macros.svh"

    localparam int PW = tpdd_pkg::POS_W;
    localparam int KW = tpdd_pkg::KEY_W;
    localparam int LW = tpdd_pkg::LEN_W;

    // parser state
    logic [PW-1:0]        pos_reg, pos_next;
    tpdd_pkg::phase_t     phase_reg, phase_next;
    logic [KW-1:0]        key1_reg, key1_next;
    logic [KW-1:0]        key2_reg, key2_next;
    logic [KW-1:0]        cnt_reg, cnt_next;
    logic [KW-1:0]        asm_reg, asm_next;
    logic [LW-1:0]        left1_reg, left1_next;
    logic [LW-1:0]        left2_reg, left2_next;
    logic [LW-1:0]        leftc_reg, leftc_next;
    logic                 stop_reg, stop_next;

    // output side
    logic                 out_valid_reg, skid_valid_reg;
    tpdd_pkg::result_t    out_data_reg, skid_data_reg;
    tpdd_pkg::result_t    res;

    logic                 s_acc;
    logic                 emit;
    logic                 emit_first;
    logic                 adv;
    logic [PW-1:0]        p;
    logic [3:0]           off;
    logic [6:0]           m;
    logic [6:0]           r25;
    logic [6:0]           r5;
    logic [LW-1:0]        la, lb, lc;
    logic                 load_out;

    assign s_tready = !skid_valid_reg;
    assign s_acc    = s_tvalid && s_tready;

    // split a long code into its three field lengths
    always_comb begin
        m = s_tdata[6:0];
        priority if (m >= 7'd100) begin
            la = 3'd4; r25 = m - 7'd100;
        end else if (m >= 7'd75) begin
            la = 3'd3; r25 = m - 7'd75;
        end else if (m >= 7'd50) begin
            la = 3'd2; r25 = m - 7'd50;
        end else if (m >= 7'd25) begin
            la = 3'd1; r25 = m - 7'd25;
        end else begin
            la = 3'd0; r25 = m;
        end
        priority if (r25 >= 7'd20) begin
            lb = 3'd4; r5 = r25 - 7'd20;
        end else if (r25 >= 7'd15) begin
            lb = 3'd3; r5 = r25 - 7'd15;
        end else if (r25 >= 7'd10) begin
            lb = 3'd2; r5 = r25 - 7'd10;
        end else if (r25 >= 7'd5) begin
            lb = 3'd1; r5 = r25 - 7'd5;
        end else begin
            lb = 3'd0; r5 = r25;
        end
        lc = r5[LW-1:0];
    end

    // decode one accepted byte
    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        key1_next  = key1_reg;
        key2_next  = key2_reg;
        cnt_next   = cnt_reg;
        asm_next   = asm_reg;
        left1_next = left1_reg;
        left2_next = left2_reg;
        leftc_next = leftc_reg;
        stop_next  = stop_reg;
        emit       = 1'b0;
        emit_first = 1'b0;
        adv        = 1'b0;
        p          = pos_reg;
        off        = 4'd0;
        if (s_acc) begin
            // a page mark restarts the parser on this byte
            if (s_tuser) begin
                pos_next   = '0;
                phase_next = tpdd_pkg::PH_HEADER;
                key1_next  = '0;
                key2_next  = '0;
                cnt_next   = '0;
                asm_next   = '0;
                left1_next = '0;
                left2_next = '0;
                leftc_next = '0;
                stop_next  = 1'b0;
            end
            if (!stop_next && pos_next < PW'(tpdd_pkg::PAGE_BYTES)) begin
                p        = pos_next;
                pos_next = p + PW'(1);
                off      = 4'(p - PW'(tpdd_pkg::HEADER_BYTES));
                if (p < PW'(tpdd_pkg::HEADER_BYTES)) begin
                    phase_next = tpdd_pkg::PH_HEADER;
                end else if (p < PW'(tpdd_pkg::HEADER_BYTES + tpdd_pkg::FIRST_BYTES)) begin
                    // full first triple, three big-endian words
                    phase_next = tpdd_pkg::PH_FIRST;
                    asm_next   = {asm_next[KW-9:0], s_tdata};
                    if (off[1:0] == 2'd3) begin
                        unique case (off[3:2])
                            2'd0:    key1_next = asm_next;
                            2'd1:    key2_next = asm_next;
                            default: cnt_next  = asm_next;
                        endcase
                        if (off[3:2] == 2'd2) begin
                            phase_next = tpdd_pkg::PH_CODE;
                            emit       = 1'b1;
                            emit_first = 1'b1;
                        end
                        asm_next = '0;
                    end
                end else if (phase_next == tpdd_pkg::PH_FA ||
                             phase_next == tpdd_pkg::PH_FB ||
                             phase_next == tpdd_pkg::PH_FC) begin
                    // gather field bytes
                    asm_next = {asm_next[KW-9:0], s_tdata};
                    unique case (phase_next)
                        tpdd_pkg::PH_FA: begin
                            left1_next = left1_next - LW'(1);
                            if (left1_next == '0) begin
                                key1_next = key1_next + asm_next;
                                adv       = 1'b1;
                            end
                        end
                        tpdd_pkg::PH_FB: begin
                            left2_next = left2_next - LW'(1);
                            if (left2_next == '0) begin
                                key2_next = asm_next;
                                adv       = 1'b1;
                            end
                        end
                        default: begin
                            leftc_next = leftc_next - LW'(1);
                            if (leftc_next == '0) begin
                                cnt_next = asm_next + KW'(1);
                                adv      = 1'b1;
                            end
                        end
                    endcase
                end else begin
                    // code byte
                    phase_next = tpdd_pkg::PH_CODE;
                    if (s_tdata == tpdd_pkg::CODE_END) begin
                        stop_next = 1'b1;
                    end else if (!s_tdata[7]) begin
                        cnt_next  = KW'(s_tdata[6:5]) + KW'(1);
                        key2_next = key2_next + KW'(s_tdata[4:0]);
                        emit      = 1'b1;
                    end else if (m >= tpdd_pkg::REPEAT_MIN) begin
                        emit = 1'b1;
                    end else begin
                        left1_next = la;
                        left2_next = lb;
                        leftc_next = lc;
                        if (la != '0 && lb == '0) begin
                            key2_next = '0;
                        end
                        if (lc == '0) begin
                            cnt_next = KW'(1);
                        end
                        adv = 1'b1;
                    end
                end
                // step to the next field with bytes, or finish the entry
                if (adv) begin
                    asm_next = '0;
                    priority if (left1_next != '0) begin
                        phase_next = tpdd_pkg::PH_FA;
                    end else if (left2_next != '0) begin
                        phase_next = tpdd_pkg::PH_FB;
                    end else if (leftc_next != '0) begin
                        phase_next = tpdd_pkg::PH_FC;
                    end else begin
                        phase_next = tpdd_pkg::PH_CODE;
                        emit       = 1'b1;
                    end
                end
            end
        end
        res.first     = emit_first;
        res.count     = cnt_next;
        res.second    = key2_next;
        res.first_key = key1_next;
    end

    // parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            phase_reg <= tpdd_pkg::PH_HEADER;
            key1_reg  <= '0;
            key2_reg  <= '0;
            cnt_reg   <= '0;
            asm_reg   <= '0;
            left1_reg <= '0;
            left2_reg <= '0;
            leftc_reg <= '0;
            stop_reg  <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            key1_reg  <= key1_next;
            key2_reg  <= key2_next;
            cnt_reg   <= cnt_next;
            asm_reg   <= asm_next;
            left1_reg <= left1_next;
            left2_reg <= left2_next;
            leftc_reg <= leftc_next;
            stop_reg  <= stop_next;
        end
    end

    // result register and skid: advance when taken, park a new result on stall
    assign load_out = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (load_out) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= emit;
            end
        end else if (emit) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end
        if (!load_out && emit) begin
            skid_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.count, out_data_reg.second, out_data_reg.first_key};
    assign m_tuser  = out_data_reg.first;

    // checks on the parser and the output buffering
    `TPDD_ASSERT_IMP(a_skid_needs_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `TPDD_ASSERT_IMP(a_pos_bound, aclk, aresetn, 1'b1, pos_reg <= PW'(tpdd_pkg::PAGE_BYTES))
    `TPDD_ASSERT_IMP(a_fa_has_bytes, aclk, aresetn, phase_reg == tpdd_pkg::PH_FA, left1_reg != '0)
    `TPDD_ASSERT_IMP(a_stopped_silent, aclk, aresetn, stop_reg && !s_tuser, !emit)
    `TPDD_ASSERT_NXT(a_emit_shows, aclk, aresetn, emit, m_tvalid)

endmodule
